/* rtl/chs_pkg.sv */
// ----------------------------------------------------------------------------
// chs_pkg
// shared types and constants of the chained hash set unit
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

   localparam int unsigned NumBucketsDefault  = 16;
   localparam int unsigned BucketDepthDefault = 8;
   localparam int unsigned KeyWidth           = 31;
   localparam int unsigned KindWidth          = 2;
   localparam int unsigned CountWidth         = 5;
   localparam int unsigned StatusWidth        = 3;
   localparam int unsigned BucketWidth        = 4;
   localparam int unsigned PositionWidth      = 3;
   localparam logic [CountWidth-1:0] CountReset = 5'd10;

   typedef enum logic [KindWidth-1:0] {
      KIND_INSERT = 2'd0,
      KIND_SEARCH = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_REMOVED   = 3'd4,
      ST_RM_MISS   = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   // classified request handed from front to back
   typedef struct packed {
      kind_type                kind;
      logic [KeyWidth-1:0]     key;
      logic [BucketWidth-1:0]  bucket;
   } job_type;

   typedef struct packed {
      status_type                status;
      logic [BucketWidth-1:0]    bucket;
      logic [PositionWidth-1:0]  position;
   } result_type;

endpackage

`default_nettype wire

/* rtl/chained_hash_set_unit.sv */
// ----------------------------------------------------------------------------
// chained_hash_set_unit
// set of 31-bit keys in chained buckets, insert / search / remove
// ----------------------------------------------------------------------------
// channel   direction  contents
// req_      in         tuser kind, tdata key
// rsp_      out        tdata status, bucket, position
// csr_      in         bucket count write
// front: serial key remainder, one request at a time
// back: reads and compares the bucket entries in turn, shifts later entries down on remove
// front and back overlap through a two-entry queue
// sync reset clears fill counts; key store needs no clear
// either side stalls on its own
`default_nettype none

module chained_hash_set_unit #(
   parameter int unsigned NUM_BUCKETS  = chs_pkg::NumBucketsDefault,
   parameter int unsigned BUCKET_DEPTH = chs_pkg::BucketDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [4:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // kind
   input  wire logic [31:0] req_tdata,   // key[30:0], pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // status[2:0], bucket[6:3], position[9:7], pad
);
   import chs_pkg::*;

   logic [CountWidth-1:0] count_ff;
   logic                  fq_valid, fq_ready, qb_valid, qb_ready;
   job_type               fq_job, qb_job;
   result_type            res;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= CountReset;
      else if (csr_we) count_ff <= csr_wdata;
   end

   chs_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
      .clock, .reset, .bucket_count(count_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_kind(kind_type'(req_tuser)), .in_key(req_tdata[KeyWidth-1:0]),
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
   );

   chs_queue u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
   );

   chs_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
      .clock, .reset,
      .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {6'd0, res.position, res.bucket, res.status};

endmodule

`default_nettype wire

/* rtl/chs_front.sv */
// ----------------------------------------------------------------------------
// chs_front
// accepts requests and computes the bucket by a serial remainder
// ----------------------------------------------------------------------------
`default_nettype none

module chs_front #(
   parameter int unsigned NUM_BUCKETS = chs_pkg::NumBucketsDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [chs_pkg::CountWidth-1:0]     bucket_count,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire chs_pkg::kind_type                  in_kind,
   input  wire logic [chs_pkg::KeyWidth-1:0]       in_key,
   output logic                                    job_valid,
   input  wire logic                               job_ready,
   output chs_pkg::job_type                        job
);
   import chs_pkg::*;

   localparam int unsigned StepWidth = $clog2(KeyWidth + 1);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_type;

   state_type                 state_ff, state_in;
   logic [StepWidth-1:0]      step_ff, step_in;
   logic [KeyWidth-1:0]       key_ff, key_in;
   logic [KeyWidth-1:0]       shift_ff, shift_in;
   kind_type                  kind_ff, kind_in;
   logic [CountWidth:0]       rem_ff, rem_in;
   logic [CountWidth-1:0]     div_ff, div_in;
   logic [CountWidth:0]       trial;

   logic [CountWidth-1:0] eff_count;
   always_comb begin
      eff_count = bucket_count;
      if (bucket_count == '0) eff_count = CountWidth'(1);
      if (32'(bucket_count) > NUM_BUCKETS) eff_count = CountWidth'(NUM_BUCKETS);
   end

   assign trial = {rem_ff[CountWidth-1:0], shift_ff[KeyWidth-1]};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      key_in   = key_ff;
      shift_in = shift_ff;
      kind_in  = kind_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               state_in = S_DIV;
               key_in   = in_key;
               shift_in = in_key;
               kind_in  = in_kind;
               rem_in   = '0;
               div_in   = eff_count;
               step_in  = '0;
            end
         end
         S_DIV: begin
            rem_in   = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
            shift_in = {shift_ff[KeyWidth-2:0], 1'b0};
            step_in  = step_ff + 1'b1;
            if (step_ff == StepWidth'(KeyWidth - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (job_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff  <= step_in;
      key_ff   <= key_in;
      shift_ff <= shift_in;
      kind_ff  <= kind_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign in_ready   = (state_ff == S_IDLE);
   assign job_valid  = (state_ff == S_DONE);
   assign job.kind   = kind_ff;
   assign job.key    = key_ff;
   assign job.bucket = rem_ff[BucketWidth-1:0];

endmodule

`default_nettype wire

/* rtl/chs_queue.sv */
// ----------------------------------------------------------------------------
// chs_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module chs_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire chs_pkg::job_type in_job,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output chs_pkg::job_type      out_job
);
   import chs_pkg::*;

   job_type    slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = slot_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) slot_ff[wptr_ff] <= in_job;
   end

endmodule

`default_nettype wire

/* rtl/chs_back.sv */
// ----------------------------------------------------------------------------
// chs_back
// scans one bucket, then inserts, reports or removes with shift-down
// ----------------------------------------------------------------------------
`default_nettype none

module chs_back #(
   parameter int unsigned NUM_BUCKETS  = chs_pkg::NumBucketsDefault,
   parameter int unsigned BUCKET_DEPTH = chs_pkg::BucketDepthDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 job_valid,
   output logic                      job_ready,
   input  wire chs_pkg::job_type     job,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output chs_pkg::result_type       out_result
);
   import chs_pkg::*;

   localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int unsigned PW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int unsigned FW = $clog2(BUCKET_DEPTH + 1);
   localparam int unsigned AW = BW + PW;
   localparam int unsigned Entries = NUM_BUCKETS * (2 ** PW);

   typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_SHRD, S_SHWR, S_OUT} state_type;

   logic [KeyWidth-1:0] mem [Entries];
   logic [FW-1:0]       fill_ff [NUM_BUCKETS];

   state_type           state_ff;
   job_type             job_ff;
   logic [FW-1:0]       idx_ff;
   logic [FW-1:0]       cur_fill_ff;
   logic [KeyWidth-1:0] rdata_ff;
   logic [AW-1:0]       raddr;
   logic                re;
   logic [AW-1:0]       waddr;
   logic [KeyWidth-1:0] wdata;
   logic                we;
   result_type          res_ff;
   logic [BW-1:0]       bidx;

   assign bidx = BW'(job_ff.bucket);

   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem[raddr];
      if (we) mem[waddr] <= wdata;
   end

   always_comb begin
      re    = 1'b0;
      raddr = {bidx, idx_ff[PW-1:0]};
      we    = 1'b0;
      waddr = {bidx, idx_ff[PW-1:0]};
      wdata = job_ff.key;
      unique case (state_ff)
         S_RD: re = (idx_ff < cur_fill_ff);
         S_SHRD: re = 1'b1;
         S_SHWR: begin
            we    = 1'b1;
            waddr = {bidx, PW'(idx_ff - 1'b1)};
            wdata = rdata_ff;
         end
         S_OUT: begin
            we = (job_ff.kind == KIND_INSERT) && (res_ff.status == ST_INSERTED);
            waddr = {bidx, cur_fill_ff[PW-1:0]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < NUM_BUCKETS; i++) fill_ff[i] <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff      <= job;
                  cur_fill_ff <= fill_ff[BW'(job.bucket)];
                  idx_ff      <= '0;
                  state_ff    <= S_RD;
               end
            end
            S_RD: begin
               if (idx_ff < cur_fill_ff) begin
                  state_ff <= S_CMP;
               end else begin
                  res_ff.bucket <= job_ff.bucket;
                  res_ff.position <= '0;
                  unique case (job_ff.kind)
                     KIND_INSERT: begin
                        if (cur_fill_ff >= FW'(BUCKET_DEPTH)) begin
                           res_ff.status <= ST_FULL;
                        end else begin
                           res_ff.status   <= ST_INSERTED;
                           res_ff.position <= PositionWidth'(cur_fill_ff);
                           fill_ff[bidx]   <= cur_fill_ff + 1'b1;
                        end
                     end
                     KIND_REMOVE: res_ff.status <= ST_RM_MISS;
                     default: res_ff.status <= ST_NOT_FOUND;
                  endcase
                  state_ff <= S_OUT;
               end
            end
            S_CMP: begin
               if (rdata_ff == job_ff.key) begin
                  res_ff.bucket   <= job_ff.bucket;
                  res_ff.position <= PositionWidth'(idx_ff);
                  unique case (job_ff.kind)
                     KIND_INSERT: begin
                        res_ff.status <= ST_DUPLICATE;
                        state_ff      <= S_OUT;
                     end
                     KIND_REMOVE: begin
                        res_ff.status <= ST_REMOVED;
                        fill_ff[bidx] <= cur_fill_ff - 1'b1;
                        idx_ff        <= idx_ff + 1'b1;
                        state_ff      <= S_SHRD;
                     end
                     default: begin
                        res_ff.status <= ST_FOUND;
                        state_ff      <= S_OUT;
                     end
                  endcase
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_SHRD: begin
               if (idx_ff < cur_fill_ff) state_ff <= S_SHWR;
               else state_ff <= S_OUT;
            end
            S_SHWR: begin
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_SHRD;
            end
            S_OUT: begin
               if (out_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign job_ready  = (state_ff == S_IDLE);
   assign out_valid  = (state_ff == S_OUT);
   assign out_result = res_ff;

endmodule

`default_nettype wire
